### hw/rtl/jump_phase_sequencer_top_defines.svh
// Assertion macros used by the top level of the jump phase sequencer RTL.
`ifndef JUMP_PHASE_SEQUENCER_TOP_DEFINES_SVH
`define JUMP_PHASE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JPS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define JPS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/jps_pkg.sv
// Types and constants of the jump phase sequencer.
`default_nettype none

package jps_pkg;

    // Jump phases, in the order the sequencer walks through them.
    typedef enum logic [2:0] {
        PH_STAND   = 3'd0,
        PH_CROUCH  = 3'd1,
        PH_TAKEOFF = 3'd2,
        PH_AIR     = 3'd3,
        PH_LANDING = 3'd4,
        PH_RISE    = 3'd5
    } t_phase;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CONFIRM_FRAMES  = 2'd0;
    localparam logic [1:0] CFG_FALLBACK_FRAMES = 2'd1;

    // Configuration reset values.
    localparam logic [2:0] CONFIRM_FRAMES_RST  = 3'd2;
    localparam logic [2:0] FALLBACK_FRAMES_RST = 3'd4;

    // Counter saturation limits.
    localparam logic [3:0] CNT_MAX = 4'd15;
    localparam logic [2:0] FB_MAX  = 3'd7;

    // Input item kinds.
    localparam logic KIND_FRAME   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Configuration register file contents.
    typedef struct packed {
        logic [2:0] confirm_frames;
        logic [2:0] fallback_frames;
    } t_cfg;

    // One score frame as held in the input register.
    typedef struct packed {
        logic signed [15:0] score_stand;
        logic signed [15:0] score_crouch;
        logic signed [15:0] score_takeoff;
        logic signed [15:0] score_air;
        logic signed [15:0] score_landing;
        logic signed [15:0] score_rise;
        logic        [2:0]  top_class;
    } t_frame;

    // Sequencer state, including the last emitted label.
    typedef struct packed {
        t_phase     phase;
        logic [3:0] confirm_count;
        logic [2:0] fallback_count;
        logic [2:0] label;
    } t_seq_state;

endpackage

`default_nettype wire

### hw/rtl/jps_cfg.sv
// Configuration registers of the jump phase sequencer.
`default_nettype none

module jps_cfg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [2:0]    i_cfg_wdata,
    output jps_pkg::t_cfg      o_cfg
);
    import jps_pkg::*;

    t_cfg r_cfg;

    // Register writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_frames  <= CONFIRM_FRAMES_RST;
            r_cfg.fallback_frames <= FALLBACK_FRAMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CONFIRM_FRAMES:  r_cfg.confirm_frames  <= i_cfg_wdata;
                CFG_FALLBACK_FRAMES: r_cfg.fallback_frames <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/jps_step.sv
// Next-state logic of the jump phase sequencer for one score frame.
`default_nettype none

module jps_step (
    input  jps_pkg::t_cfg       i_cfg,
    input  jps_pkg::t_frame     i_frame,
    input  jps_pkg::t_seq_state i_state,
    output jps_pkg::t_seq_state o_state
);
    import jps_pkg::*;

    t_phase             nxt_phase;
    logic signed [15:0] s_cur;
    logic signed [15:0] s_nxt;
    logic               cur_gt;
    logic               cur_lt;
    logic [3:0]         cnt_inc;
    logic [3:0]         cnt_inc2;
    logic [2:0]         fb_inc;
    logic               stand_or_rise;

    // Score of the current phase and of the phase that follows it.
    function automatic logic signed [15:0] score_of(input t_frame f, input t_phase p);
        logic signed [15:0] s;
        case (p)
            PH_STAND:   s = f.score_stand;
            PH_CROUCH:  s = f.score_crouch;
            PH_TAKEOFF: s = f.score_takeoff;
            PH_AIR:     s = f.score_air;
            PH_LANDING: s = f.score_landing;
            PH_RISE:    s = f.score_rise;
            default:    s = f.score_stand;
        endcase
        return s;
    endfunction

    assign nxt_phase = (i_state.phase == PH_RISE) ? PH_STAND : t_phase'(i_state.phase + 3'd1);
    assign s_cur     = score_of(i_frame, i_state.phase);
    assign s_nxt     = score_of(i_frame, nxt_phase);
    assign cur_gt    = s_cur > s_nxt;
    assign cur_lt    = s_cur < s_nxt;

    // Saturating counter increments; entering crouch bumps the count twice.
    assign cnt_inc  = (i_state.confirm_count == CNT_MAX) ? CNT_MAX : i_state.confirm_count + 4'd1;
    assign cnt_inc2 = (cnt_inc == CNT_MAX) ? CNT_MAX : cnt_inc + 4'd1;
    assign fb_inc   = (i_state.fallback_count == FB_MAX) ? FB_MAX : i_state.fallback_count + 3'd1;

    assign stand_or_rise = (i_frame.top_class == 3'(PH_STAND))
                        || (i_frame.top_class == 3'(PH_RISE));

    // Phase transition rules.
    always_comb begin
        o_state = i_state;
        case (i_state.phase)
            PH_STAND: begin
                if (cur_gt) begin
                    o_state.label         = 3'(PH_STAND);
                    o_state.confirm_count = 4'd0;
                end else if (cur_lt) begin
                    o_state.label         = 3'(PH_STAND);
                    o_state.confirm_count = cnt_inc;
                    if (cnt_inc >= {1'b0, i_cfg.confirm_frames}) begin
                        o_state.phase         = PH_CROUCH;
                        o_state.label         = 3'(PH_CROUCH);
                        o_state.confirm_count = cnt_inc2;
                    end
                end
            end
            PH_CROUCH: begin
                o_state.label = 3'(PH_CROUCH);
                if (cur_lt) begin
                    o_state.confirm_count  = cnt_inc;
                    o_state.fallback_count = 3'd0;
                    if (cnt_inc >= {1'b0, i_cfg.confirm_frames}) begin
                        o_state.phase         = PH_TAKEOFF;
                        o_state.label         = 3'(PH_TAKEOFF);
                        o_state.confirm_count = 4'd0;
                    end
                end else if (stand_or_rise) begin
                    o_state.fallback_count = fb_inc;
                    o_state.confirm_count  = 4'd0;
                    if (fb_inc >= i_cfg.fallback_frames) begin
                        o_state.phase          = PH_STAND;
                        o_state.label          = 3'(PH_STAND);
                        o_state.fallback_count = 3'd0;
                    end
                end else begin
                    o_state.fallback_count = 3'd0;
                    o_state.confirm_count  = 4'd0;
                end
            end
            PH_TAKEOFF, PH_AIR, PH_LANDING, PH_RISE: begin
                o_state.label = 3'(i_state.phase);
                if (cur_gt) begin
                    o_state.confirm_count = 4'd0;
                end else begin
                    o_state.confirm_count = cnt_inc;
                    if (cnt_inc >= {1'b0, i_cfg.confirm_frames}) begin
                        o_state.phase         = nxt_phase;
                        o_state.label         = 3'(nxt_phase);
                        o_state.confirm_count = 4'd0;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/jump_phase_sequencer_top.sv
// Top level of the jump phase sequencer: handshakes, state and result registers.
`default_nettype none
`include "jump_phase_sequencer_top_defines.svh"

// The sequencer takes one item per clock cycle while the input is not stalled. An
// accepted item is held in the input register, then a single pass of next-state
// logic loads the state and result registers, which drive the phase label of a
// score frame at the output. A
// restart item forces the stand phase and produces no result; it is consumed
// even while a result waits at the output. Input stall rises only when the input
// register holds a score frame and the result register is full and stalled.
// Configuration registers may be written only while no item is in flight.
module jump_phase_sequencer_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Configuration write port
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [2:0]         i_cfg_wdata,
    // Input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_kind,
    input  wire logic signed [15:0] i_score_stand,
    input  wire logic signed [15:0] i_score_crouch,
    input  wire logic signed [15:0] i_score_takeoff,
    input  wire logic signed [15:0] i_score_air,
    input  wire logic signed [15:0] i_score_landing,
    input  wire logic signed [15:0] i_score_rise,
    input  wire logic [2:0]         i_top_class,
    // Result item channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_phase_label
);
    import jps_pkg::*;

    t_cfg       cfg;
    logic       r_in_valid;
    logic       r_in_kind;
    t_frame     r_in_frame;
    t_seq_state r_state;
    t_seq_state n_state;
    logic       r_out_valid;
    logic       in_accept;
    logic       out_free;
    logic       process;

    jps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    jps_step u_step (
        .i_cfg   (cfg),
        .i_frame (r_in_frame),
        .i_state (r_state),
        .o_state (n_state)
    );

    // Handshake control: a restart never waits for the result register.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign process    = r_in_valid && ((r_in_kind == KIND_RESTART) || out_free);
    assign o_in_stall = r_in_valid && !process;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_kind                <= i_kind;
            r_in_frame.score_stand   <= i_score_stand;
            r_in_frame.score_crouch  <= i_score_crouch;
            r_in_frame.score_takeoff <= i_score_takeoff;
            r_in_frame.score_air     <= i_score_air;
            r_in_frame.score_landing <= i_score_landing;
            r_in_frame.score_rise    <= i_score_rise;
            r_in_frame.top_class     <= i_top_class;
        end
    end

    // Sequencer state; the label field doubles as the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= PH_STAND;
            r_state.confirm_count  <= 4'd0;
            r_state.fallback_count <= 3'd0;
            r_state.label          <= 3'(PH_STAND);
        end else if (process) begin
            if (r_in_kind == KIND_RESTART) begin
                r_state.phase <= PH_STAND;
            end else begin
                r_state <= n_state;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process && (r_in_kind == KIND_FRAME)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_phase_label = r_state.label;

    // Checks on the sequencing logic.
    `JPS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_in_stall,
        r_in_valid && (r_in_kind == KIND_FRAME) && r_out_valid && i_out_stall,
        "input stalled without a blocked score frame")
    `JPS_ASSERT_NEXT(a_restart_stand, i_clk, i_rst_n, process && (r_in_kind == KIND_RESTART),
        (r_state.phase == PH_STAND) && $stable(r_state.label),
        "restart did not force the stand phase")
    `JPS_ASSERT_NEXT(a_advance_clears, i_clk, i_rst_n,
        process && (r_in_kind == KIND_FRAME) && (n_state.phase != r_state.phase)
            && (n_state.phase != PH_CROUCH),
        r_state.confirm_count == 4'd0,
        "confirmation count not cleared after a phase change")
    `JPS_ASSERT_NEXT(a_fallback_clears, i_clk, i_rst_n,
        process && (r_in_kind == KIND_FRAME) && (r_state.phase == PH_CROUCH)
            && (n_state.phase == PH_STAND),
        (r_state.fallback_count == 3'd0) && o_out_valid && (o_phase_label == 3'(PH_STAND)),
        "fallback from crouch left stale state")

endmodule

`default_nettype wire
